// ===== sv/imu_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// IMU frame deframer assertion macros
// Shared concurrent assertion helpers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_DEFRAMER_MACROS_SVH
`define IMU_FRAME_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define IFD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define IFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define IFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define IFD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define IFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU frame deframer package
// Frame format constants and the types shared between the deframer parts.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam int         FrameLen  = 11;
  localparam int         SumPos    = 10;
  localparam logic [7:0] IdLow     = 8'h50;
  localparam logic [7:0] IdHigh    = 8'h5A;
  localparam int         NumCodes  = 11;
  localparam int         FillW     = 4;
  localparam int         QueueDepth = 2;

  typedef logic [7:0] byte_t;

  // One decoded frame on its way from the window to the group logic.
  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/ifd_window.sv =====
// ----------------------------------------------------------------------------
// IMU frame deframer window
// Collects bytes after a header, checks the additive checksum, realigns on a
// bad frame and pushes frames with a known id into the frame queue.
// ----------------------------------------------------------------------------
`include "imu_frame_deframer_macros.svh"

module ifd_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ifd_pkg::byte_t     data_byte_i,
  input  ifd_pkg::q_status_t q_status_i,
  output logic               push_o,
  output ifd_pkg::frame_t    frame_o
);
  import ifd_pkg::*;

  byte_t            win_q [SumPos];
  byte_t            win_d [SumPos];
  logic [FillW-1:0] fill_q, fill_d;
  byte_t            full_w [FrameLen];
  byte_t            sum;
  logic [3:0]       hdr_pos;
  logic             hdr_found;
  logic [4:0]       src_idx;
  logic             accept;
  byte_t            id;
  byte_t            code_wide;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int i = 0; i < SumPos; i++) begin
      full_w[i] = win_q[i];
    end
    full_w[SumPos] = data_byte_i;
  end

  // Wrapping 8-bit sum of the ten stored bytes, as a balanced tree.
  assign sum = ((win_q[0] + win_q[1]) + (win_q[2] + win_q[3]))
             + ((win_q[4] + win_q[5]) + (win_q[6] + win_q[7]))
             + (win_q[8] + win_q[9]);

  // First header byte after position 0 in the full window.
  always_comb begin
    hdr_pos   = '0;
    hdr_found = 1'b0;
    for (int i = SumPos; i >= 1; i--) begin
      if (full_w[i] == HdrByte) begin
        hdr_pos   = 4'(i);
        hdr_found = 1'b1;
      end
    end
  end

  assign id        = win_q[1];
  assign code_wide = id - IdLow;

  always_comb begin
    frame_o.code  = code_wide[3:0];
    frame_o.word0 = {win_q[3], win_q[2]};
    frame_o.word1 = {win_q[5], win_q[4]};
    frame_o.word2 = {win_q[7], win_q[6]};
    frame_o.word3 = {win_q[9], win_q[8]};
  end

  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    push_o  = 1'b0;
    src_idx = '0;
    if (accept) begin
      if (fill_q == '0) begin
        if (data_byte_i == HdrByte) begin
          win_d[0] = data_byte_i;
          fill_d   = FillW'(1);
        end
      end else if (fill_q < FillW'(SumPos)) begin
        win_d[fill_q] = data_byte_i;
        fill_d        = fill_q + FillW'(1);
      end else if (sum == data_byte_i) begin
        fill_d = '0;
        push_o = (id >= IdLow) && (id <= IdHigh);
      end else if (hdr_found) begin
        // Slide the window so that the found header becomes byte 0.
        for (int j = 0; j < SumPos; j++) begin
          src_idx = 5'(j) + 5'(hdr_pos);
          if (src_idx <= 5'(SumPos)) begin
            win_d[j] = full_w[src_idx[3:0]];
          end
        end
        fill_d = FillW'(FrameLen) - hdr_pos;
      end else begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  `IFD_ASSERT_ALWAYS(a_fill_range, clk_i, rst_ni, fill_q <= FillW'(SumPos))
  `IFD_ASSERT_IMPLIES(a_window_starts_hdr, clk_i, rst_ni, fill_q != '0, win_q[0] == HdrByte)
  `IFD_ASSERT_IMPLIES(a_push_needs_full, clk_i, rst_ni, push_o, accept && fill_q == FillW'(SumPos))

endmodule

// ===== sv/ifd_fifo.sv =====
// ----------------------------------------------------------------------------
// IMU frame deframer queue
// Small register queue of decoded frames between the window and group logic.
// ----------------------------------------------------------------------------
`include "imu_frame_deframer_macros.svh"

module ifd_fifo #(
  parameter int DEPTH = ifd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ifd_pkg::frame_t    wr_data_i,
  input  logic               pop_i,
  output ifd_pkg::frame_t    rd_data_o,
  output ifd_pkg::q_status_t status_o
);
  import ifd_pkg::*;

  // DEPTH must be at least 2; the module itself does not enforce this.
  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  frame_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign rd_data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `IFD_ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !status_o.full)
  `IFD_ASSERT_IMPLIES(a_no_underflow, clk_i, rst_ni, pop_i, !status_o.empty)
  `IFD_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(DEPTH))

endmodule

// ===== sv/ifd_group.sv =====
// ----------------------------------------------------------------------------
// IMU frame deframer group tracker
// Tracks which frame ids belong to the pending sample group, flags the frame
// that opens a new group and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "imu_frame_deframer_macros.svh"

module ifd_group (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ifd_pkg::q_status_t q_status_i,
  input  ifd_pkg::frame_t    q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         frame_code_o,
  output logic [15:0]        payload_word0_o,
  output logic [15:0]        payload_word1_o,
  output logic [15:0]        payload_word2_o,
  output logic [15:0]        payload_word3_o,
  output logic               new_sample_o
);
  import ifd_pkg::*;

  logic [NumCodes-1:0] seen_q, seen_d;
  logic                pending_q, pending_d;
  logic                out_valid_q, out_valid_d;
  frame_t              res_q;
  logic                flag_q;
  logic                flag;
  logic [NumCodes-1:0] code_bit;

  assign pop_o    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign code_bit = NumCodes'(1) << q_data_i.code;
  assign flag     = seen_q[q_data_i.code] && pending_q;

  always_comb begin
    seen_d      = seen_q;
    pending_d   = pending_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      // A repeated id while a group is open closes that group.
      seen_d      = (flag ? '0 : seen_q) | code_bit;
      pending_d   = 1'b1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q  <= q_data_i;
      flag_q <= flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_code_o    = res_q.code;
  assign payload_word0_o = res_q.word0;
  assign payload_word1_o = res_q.word1;
  assign payload_word2_o = res_q.word2;
  assign payload_word3_o = res_q.word3;
  assign new_sample_o    = flag_q;

  `IFD_ASSERT_IMPLIES(a_seen_needs_pending, clk_i, rst_ni, seen_q != '0, pending_q)
  `IFD_ASSERT_IMPLIES(a_code_range, clk_i, rst_ni, pop_o, q_data_i.code < 4'(NumCodes))
  `IFD_ASSERT_NEXT(a_pop_sets_bit, clk_i, rst_ni, pop_o, seen_q != '0 && out_valid_q)

endmodule

// ===== sv/imu_frame_deframer.sv =====
// Timing: a frame's result is written into the frame queue on the edge that
// accepts its checksum byte and moves to the output register once it is free.
// Throughput: one byte per cycle; input stalls only while the frame queue
// (two entries by default) is full because the output side is stalled.
// Reset clears the window fill, the group tracking and the queue at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// IMU frame deframer
// Byte-serial sync and checksum frame parser with sample group flagging.
// ----------------------------------------------------------------------------
module imu_frame_deframer #(
  parameter int QUEUE_DEPTH = ifd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  frame_code_o,
  output logic [15:0] payload_word0_o,
  output logic [15:0] payload_word1_o,
  output logic [15:0] payload_word2_o,
  output logic [15:0] payload_word3_o,
  output logic        new_sample_o
);
  import ifd_pkg::*;

  q_status_t q_status;
  frame_t    push_frame;
  frame_t    pop_frame;
  logic      push;
  logic      pop;

  ifd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .frame_o     (push_frame)
  );

  ifd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (push_frame),
    .pop_i     (pop),
    .rd_data_o (pop_frame),
    .status_o  (q_status)
  );

  ifd_group u_group (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .q_data_i        (pop_frame),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_code_o    (frame_code_o),
    .payload_word0_o (payload_word0_o),
    .payload_word1_o (payload_word1_o),
    .payload_word2_o (payload_word2_o),
    .payload_word3_o (payload_word3_o),
    .new_sample_o    (new_sample_o)
  );

endmodule
